FILE: sv/e2r_pkg.sv
// Package: widths, CORDIC constants and helpers for the Euler-to-DCM block.
package e2r_pkg;
  localparam int ANG_W = 16;
  localparam int OUT_W = 16;
  localparam int CW = 36;
  localparam int MW = 32;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q14 = 36'sd16384;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [OUT_W-1:0] ent_t;
  typedef logic signed [CW-1:0] q30_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sc_t;

  typedef struct packed {
    ang_t roll_angle;
    ang_t pitch_angle;
    ang_t yaw_angle;
  } angles_t;

  typedef struct packed {
    ent_t r00; ent_t r01; ent_t r02;
    ent_t r10; ent_t r11; ent_t r12;
    ent_t r20; ent_t r21; ent_t r22;
  } dcm_t;

  function automatic q30_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 36'sh03243F6A8;
      1: atan_q30 = 36'sh01DAC6705;
      2: atan_q30 = 36'sh00FADBAFC;
      3: atan_q30 = 36'sh007F56EA6;
      4: atan_q30 = 36'sh003FEAB76;
      5: atan_q30 = 36'sh001FFD55B;
      6: atan_q30 = 36'sh000FFFAAA;
      7: atan_q30 = 36'sh0007FFF55;
      8: atan_q30 = 36'sh0003FFFEA;
      9: atan_q30 = 36'sh0001FFFFD;
      10: atan_q30 = 36'sh0000FFFFF;
      11: atan_q30 = 36'sh00007FFFF;
      12: atan_q30 = 36'sh00003FFFF;
      13: atan_q30 = 36'sh00001FFFF;
      14: atan_q30 = 36'sh00000FFFF;
      15: atan_q30 = 36'sh000007FFF;
      16: atan_q30 = 36'sh000003FFF;
      17: atan_q30 = 36'sh000001FFF;
      18: atan_q30 = 36'sh000000FFF;
      19: atan_q30 = 36'sh0000007FF;
      20: atan_q30 = 36'sh0000003FF;
      21: atan_q30 = 36'sh0000001FF;
      22: atan_q30 = 36'sh0000000FF;
      23: atan_q30 = 36'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  // rounded Q1.30 product; sines, cosines and their products stay below 2^31
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [MW-1:0] an;
    logic signed [MW-1:0] bn;
    logic signed [2*MW-1:0] p;
    an = a[MW-1:0];
    bn = b[MW-1:0];
    p = an * bn + (64'sd1 <<< 29);
    mulq = q30_t'(p >>> 30);
  endfunction

  function automatic ent_t to_out(input q30_t v);
    q30_t r;
    r = (v + 36'sd32768) >>> 16;
    if (r > ONE_Q14) r = ONE_Q14;
    if (r < -ONE_Q14) r = -ONE_Q14;
    to_out = r[OUT_W-1:0];
  endfunction
endpackage

FILE: sv/e2r_if.sv
// Valid/ready stream interface carrying a typed payload.
interface e2r_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/e2r_cordic.sv
// One CORDIC lane: pipelined sine/cosine of a Q3.13 angle, one stage per cycle while en is high.
module e2r_cordic #(
  parameter int STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic en,
  input  e2r_pkg::ang_t angle,
  output e2r_pkg::sc_t sc
);
  localparam int N = (STAGES > e2r_pkg::ATAN_ENTRIES) ? e2r_pkg::ATAN_ENTRIES : STAGES;
  e2r_pkg::q30_t x [N+1];
  e2r_pkg::q30_t y [N+1];
  e2r_pkg::q30_t z [N+1];
  logic neg [N+1];
  e2r_pkg::q30_t z0;

  assign z0 = e2r_pkg::q30_t'(angle) <<< 17;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= e2r_pkg::GAIN_Q30;
      y[0] <= '0;
      if (z0 > e2r_pkg::HALF_PI_Q30) begin
        z[0] <= z0 - e2r_pkg::PI_Q30;
        neg[0] <= 1'b1;
      end else if (z0 < -e2r_pkg::HALF_PI_Q30) begin
        z[0] <= z0 + e2r_pkg::PI_Q30;
        neg[0] <= 1'b1;
      end else begin
        z[0] <= z0;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (!z[i][e2r_pkg::CW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - e2r_pkg::atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + e2r_pkg::atan_q30(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.s <= neg[N] ? -y[N] : y[N];
      sc.c <= neg[N] ? -x[N] : x[N];
    end
  end
endmodule

FILE: sv/e2r_merge.sv
// Merge stage: combines the three lanes' sines/cosines into the nine entries.
module e2r_merge (
  input  logic clk,
  input  logic en,
  input  e2r_pkg::sc_t r,
  input  e2r_pkg::sc_t p,
  input  e2r_pkg::sc_t w,
  output e2r_pkg::ent_t m [9]
);
  // stage A: pair products
  e2r_pkg::q30_t srsp, crsp, cpcy, cpsy, crsy, srsy, crcy, srcy, srcp, crcp, sp;
  e2r_pkg::q30_t cya, sya;
  // stage B: triple products
  e2r_pkg::q30_t t01a, t02a, t11a, t12a;
  e2r_pkg::q30_t b_cpcy, b_cpsy, b_crsy, b_srsy, b_crcy, b_srcy, b_srcp, b_crcp, b_sp;

  always_ff @(posedge clk) begin
    if (en) begin
      srsp <= e2r_pkg::mulq(r.s, p.s);
      crsp <= e2r_pkg::mulq(r.c, p.s);
      cpcy <= e2r_pkg::mulq(p.c, w.c);
      cpsy <= e2r_pkg::mulq(p.c, w.s);
      crsy <= e2r_pkg::mulq(r.c, w.s);
      srsy <= e2r_pkg::mulq(r.s, w.s);
      crcy <= e2r_pkg::mulq(r.c, w.c);
      srcy <= e2r_pkg::mulq(r.s, w.c);
      srcp <= e2r_pkg::mulq(r.s, p.c);
      crcp <= e2r_pkg::mulq(r.c, p.c);
      sp <= p.s;
      cya <= w.c;
      sya <= w.s;
      t01a <= e2r_pkg::mulq(srsp, cya);
      t02a <= e2r_pkg::mulq(crsp, cya);
      t11a <= e2r_pkg::mulq(srsp, sya);
      t12a <= e2r_pkg::mulq(crsp, sya);
      b_cpcy <= cpcy; b_cpsy <= cpsy; b_crsy <= crsy; b_srsy <= srsy;
      b_crcy <= crcy; b_srcy <= srcy; b_srcp <= srcp; b_crcp <= crcp; b_sp <= sp;
      m[0] <= e2r_pkg::to_out(b_cpcy);
      m[1] <= e2r_pkg::to_out(t01a - b_crsy);
      m[2] <= e2r_pkg::to_out(t02a + b_srsy);
      m[3] <= e2r_pkg::to_out(b_cpsy);
      m[4] <= e2r_pkg::to_out(t11a + b_crcy);
      m[5] <= e2r_pkg::to_out(t12a - b_srcy);
      m[6] <= e2r_pkg::to_out(-b_sp);
      m[7] <= e2r_pkg::to_out(b_srcp);
      m[8] <= e2r_pkg::to_out(b_crcp);
    end
  end
endmodule

FILE: sv/euler_to_rotation_matrix.sv
// Top level: ZYX Euler angles to rotation matrix, three CORDIC lanes and a merge stage.
//   channel | dir | payload
//   in_ch   | in  | roll_angle, pitch_angle, yaw_angle (Q3.13)
//   out_ch  | out | r00..r22 (Q1.14)
// One item per cycle while the output is not stalled. The pipeline registers are the
// prescale, the CORDIC stages, sign fix, two product stages and the output register.
// The whole pipeline advances only when the output slot is free or taken.
// rst clears the valid bits only; payload registers are not reset.
module euler_to_rotation_matrix #(
  parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst,
  e2r_if.sink in_ch,
  e2r_if.source out_ch
);
  localparam int N = (CORDIC_STAGES > e2r_pkg::ATAN_ENTRIES) ?
                     e2r_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int LAT = N + 5;

  logic en;
  logic [LAT-1:0] vpipe;
  e2r_pkg::sc_t scr, scp, scy;
  e2r_pkg::ent_t m [9];

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  e2r_cordic #(.STAGES(CORDIC_STAGES)) u_roll (.clk, .en, .angle(in_ch.data.roll_angle), .sc(scr));
  e2r_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (.clk, .en, .angle(in_ch.data.pitch_angle), .sc(scp));
  e2r_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (.clk, .en, .angle(in_ch.data.yaw_angle), .sc(scy));
  e2r_merge u_merge (.clk, .en, .r(scr), .p(scp), .w(scy), .m);

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_ch.valid};
    end
  end

  assign out_ch.valid = vpipe[LAT-1];
  assign out_ch.data.r00 = m[0];
  assign out_ch.data.r01 = m[1];
  assign out_ch.data.r02 = m[2];
  assign out_ch.data.r10 = m[3];
  assign out_ch.data.r11 = m[4];
  assign out_ch.data.r12 = m[5];
  assign out_ch.data.r20 = m[6];
  assign out_ch.data.r21 = m[7];
  assign out_ch.data.r22 = m[8];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline stalled");
  a_r20_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.r20 <= 16'sd16384 && out_ch.data.r20 >= -16'sd16384)
    else $error("entry out of range");
endmodule
